### rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// Scanner frame classifier package
// Shared payload types and protocol byte codes for the frame classifier.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int OffsetWidth = 9;
	localparam int LengthWidth = 17;

	// Control bytes of the scanner link.
	localparam logic [7:0] ByteNul = 8'h00;
	localparam logic [7:0] ByteStx = 8'h02;
	localparam logic [7:0] ByteEtx = 8'h03;
	localparam logic [7:0] ByteFirstText = 8'h20;

	// Frame type codes.
	localparam logic [7:0] TypeResend = 8'h05;
	localparam logic [7:0] TypeAck = 8'h06;
	localparam logic [7:0] TypeNak = 8'h15;
	localparam logic [7:0] TypeBusy = 8'h1B;
	localparam logic [7:0] TypeReply = 8'h50;
	localparam logic [7:0] TypeResult = 8'h51;
	localparam logic [7:0] TypeStatus = 8'h53;
	localparam logic [7:0] TypeReplyPerm = 8'h54;
	localparam logic [7:0] TypeBarData = 8'h60;
	localparam logic [7:0] TypeEvent = 8'h61;
	localparam logic [7:0] TypeSetupData = 8'h62;

	// Result frame id codes.
	localparam logic [7:0] ResultIdLongA = 8'h81;
	localparam logic [7:0] ResultIdLongB = 8'h82;
	localparam logic [7:0] ResultIdMid = 8'h83;

	// Bit positions in the collected status flags.
	localparam int FlAck = 0;
	localparam int FlNak = 1;
	localparam int FlBusy = 2;
	localparam int FlResend = 3;
	localparam int FlResp = 4;
	localparam int FlFrameData = 5;
	localparam int FlRaw = 6;
	localparam int FlError = 7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic                   flag_ack;
		logic                   flag_nak;
		logic                   flag_busy;
		logic                   flag_resend;
		logic                   flag_response;
		logic                   flag_frame_data;
		logic                   flag_raw_data;
		logic                   flag_error;
		logic                   aborted;
		logic [OffsetWidth-1:0] response_offset;
		logic [LengthWidth-1:0] response_length;
	} result_item_t;

endpackage

### rtl/sfc_stream_if.sv
// ----------------------------------------------------------------------------
// Scanner frame classifier stream interface
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface sfc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/scanner_frame_classifier_top.sv
// ----------------------------------------------------------------------------
// Scanner frame classifier
// Walks one received scanner buffer byte by byte and reports frame flags.
// ----------------------------------------------------------------------------
// The block takes the bytes of one buffer on the bytes channel, one item per
// byte, with last_byte set on the final byte. An accepted byte updates the walker
// in the same cycle, so a new byte can be accepted on every clock unless stalled.
// The walker follows STX framed replies, acknowledges, result and bar-data
// frames, raw barcode text and error or abort conditions.
// When the final byte is accepted, one result item with the collected flags
// and the offset and length of the last response appears on the result
// channel in the next cycle, and the walker is cleared for the next buffer.
// Bytes that carry no last_byte marker produce no result item.
// Throughput is one byte per cycle while the result channel does not stall;
// the result item for the final byte comes from the result register.
// The result register holds its item while the receiver stalls; the bytes
// channel keeps accepting while the result register is empty or is being
// drained in the same cycle.
// Reset clears the walker and drops any pending result item.
// Bytes beyond BUFFER_BYTES in one buffer are ignored.
// ----------------------------------------------------------------------------
module scanner_frame_classifier_top #(
	parameter int BUFFER_BYTES = 512
) (
	input  logic         clk,
	input  logic         arst_n,
	sfc_stream_if.sink   bytes,
	sfc_stream_if.source result
);

	// Position counter must hold BUFFER_BYTES itself; stored offsets stay below it.
	localparam int PosWidth = $clog2(BUFFER_BYTES + 1);
	localparam int StartWidth = $clog2(BUFFER_BYTES);
	localparam int LenW = sfc_pkg::LengthWidth;

	typedef enum logic [2:0] {
		PH_AWAIT,
		PH_PEND,
		PH_SKIP,
		PH_SEEK,
		PH_RESULT_ID,
		PH_LEN_LO,
		PH_LEN_HI
	} phase_t;

	logic [PosWidth-1:0]   pos_q, n_pos;
	logic [StartWidth-1:0] fstart_q, n_fstart;
	phase_t                phase_q, n_phase;
	logic [7:0]            kind_q, n_kind;
	logic [LenW-1:0]       skip_q, n_skip;
	logic [7:0]            lenlo_q, n_lenlo;
	logic [7:0]            flags_q, n_flags;
	logic [StartWidth-1:0] lro_q, n_lro;
	logic [LenW-1:0]       lrl_q, n_lrl;
	logic                  halted_q, n_halted;
	logic                  aborted_q, n_aborted;

	logic                  out_valid_q;
	sfc_pkg::result_item_t out_q, n_out;

	logic                  accept;
	logic [7:0]            b;
	logic [PosWidth-1:0]   off;
	logic [LenW-1:0]       skip_dec;
	logic [LenW-1:0]       size;

	assign bytes.ready = !out_valid_q || result.ready;
	assign accept = bytes.valid && bytes.ready;
	assign b = bytes.payload.data_byte;
	assign result.valid = out_valid_q;
	assign result.payload = out_q;

	always_comb begin
		n_pos = pos_q;
		n_fstart = fstart_q;
		n_phase = phase_q;
		n_kind = kind_q;
		n_skip = skip_q;
		n_lenlo = lenlo_q;
		n_flags = flags_q;
		n_lro = lro_q;
		n_lrl = lrl_q;
		n_halted = halted_q;
		n_aborted = aborted_q;
		off = pos_q - PosWidth'(fstart_q);
		skip_dec = skip_q - LenW'(skip_q != '0);
		size = '0;

		if (32'(pos_q) < BUFFER_BYTES) begin
			if (!halted_q) begin
				unique case (phase_q)
					PH_AWAIT: begin
						n_fstart = StartWidth'(pos_q);
						n_kind = b;
						n_phase = PH_PEND;
					end
					PH_PEND: begin
						if (off == PosWidth'(1)) begin
							n_lenlo = b;
						end else if (kind_q != sfc_pkg::ByteStx) begin
							// The frame start byte was not STX: raw text or a stray control byte.
							if (kind_q >= sfc_pkg::ByteFirstText) begin
								n_flags[sfc_pkg::FlRaw] = 1'b1;
								n_halted = 1'b1;
							end else begin
								n_flags = '0;
								n_aborted = 1'b1;
								n_halted = 1'b1;
							end
						end else begin
							case (b) inside
								sfc_pkg::TypeAck: begin
									n_flags[sfc_pkg::FlAck] = 1'b1;
									n_skip = LenW'(2);
									n_phase = PH_SKIP;
								end
								sfc_pkg::TypeNak: begin
									n_flags[sfc_pkg::FlNak] = 1'b1;
									n_skip = LenW'(2);
									n_phase = PH_SKIP;
								end
								sfc_pkg::TypeBusy: begin
									n_flags[sfc_pkg::FlBusy] = 1'b1;
									n_skip = LenW'(2);
									n_phase = PH_SKIP;
								end
								sfc_pkg::TypeResend: begin
									n_flags[sfc_pkg::FlResend] = 1'b1;
									n_skip = LenW'(2);
									n_phase = PH_SKIP;
								end
								sfc_pkg::TypeReply, sfc_pkg::TypeReplyPerm,
								sfc_pkg::TypeEvent: begin
									if (lenlo_q == sfc_pkg::ByteNul) begin
										n_flags[sfc_pkg::FlError] = 1'b1;
										n_halted = 1'b1;
									end else if (lenlo_q == sfc_pkg::ByteEtx) begin
										// A two-byte reply; the type byte opens the next frame.
										n_flags[sfc_pkg::FlResp] = 1'b1;
										n_lro = fstart_q;
										n_lrl = LenW'(2);
										n_fstart = StartWidth'(pos_q);
										n_kind = b;
										n_phase = PH_PEND;
									end else begin
										n_skip = '0;
										n_phase = PH_SEEK;
									end
								end
								sfc_pkg::TypeStatus: begin
									n_skip = LenW'(3);
									n_phase = PH_SEEK;
								end
								sfc_pkg::TypeResult: begin
									n_flags[sfc_pkg::FlResp] = 1'b1;
									n_lro = fstart_q;
									n_lrl = LenW'(8);
									n_phase = PH_RESULT_ID;
								end
								sfc_pkg::TypeBarData: begin
									n_flags[sfc_pkg::FlFrameData] = 1'b1;
									n_lro = fstart_q;
									n_lrl = LenW'(10);
									n_phase = PH_LEN_LO;
								end
								sfc_pkg::TypeSetupData: begin
									n_flags[sfc_pkg::FlResp] = 1'b1;
									n_lro = fstart_q;
									n_lrl = LenW'(10);
									n_phase = PH_LEN_LO;
								end
								default: begin
									n_flags = '0;
									n_aborted = 1'b1;
									n_halted = 1'b1;
								end
							endcase
						end
					end
					PH_SKIP: begin
						n_skip = skip_dec;
						if (skip_dec == '0) begin
							n_phase = PH_AWAIT;
						end
					end
					PH_SEEK: begin
						if (skip_q != '0) begin
							n_skip = skip_dec;
						end else if (b == sfc_pkg::ByteEtx) begin
							n_flags[sfc_pkg::FlResp] = 1'b1;
							n_lro = fstart_q;
							n_lrl = LenW'(off) + LenW'(1);
							n_phase = PH_AWAIT;
						end else if (b == sfc_pkg::ByteNul) begin
							n_flags[sfc_pkg::FlError] = 1'b1;
							n_halted = 1'b1;
						end
					end
					PH_RESULT_ID: begin
						if (b == sfc_pkg::ResultIdLongA || b == sfc_pkg::ResultIdLongB) begin
							size = LenW'(14);
						end else if (b == sfc_pkg::ResultIdMid) begin
							size = LenW'(12);
						end else begin
							size = LenW'(8);
						end
						n_lrl = size;
						n_skip = size - LenW'(4);
						n_phase = PH_SKIP;
					end
					PH_LEN_LO: begin
						n_lenlo = b;
						n_lrl = LenW'(10) + LenW'(b);
						n_phase = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						size = LenW'(10) + LenW'(lenlo_q) + {1'b0, b, 8'h00};
						n_lrl = size;
						n_skip = size - LenW'(5);
						n_phase = PH_SKIP;
					end
					default: begin
						n_phase = PH_AWAIT;
					end
				endcase
			end
			n_pos = pos_q + PosWidth'(1);
		end

		// A reply or status frame still open at the end of the buffer lost its ETX.
		if (bytes.payload.last_byte && !n_halted && n_phase == PH_SEEK) begin
			n_flags[sfc_pkg::FlError] = 1'b1;
		end

		n_out.flag_ack = n_flags[sfc_pkg::FlAck];
		n_out.flag_nak = n_flags[sfc_pkg::FlNak];
		n_out.flag_busy = n_flags[sfc_pkg::FlBusy];
		n_out.flag_resend = n_flags[sfc_pkg::FlResend];
		n_out.flag_response = n_flags[sfc_pkg::FlResp];
		n_out.flag_frame_data = n_flags[sfc_pkg::FlFrameData];
		n_out.flag_raw_data = n_flags[sfc_pkg::FlRaw];
		n_out.flag_error = n_flags[sfc_pkg::FlError];
		n_out.aborted = n_aborted;
		if (n_aborted) begin
			n_out.response_offset = '0;
			n_out.response_length = '0;
		end else begin
			n_out.response_offset = sfc_pkg::OffsetWidth'(n_lro);
			n_out.response_length = n_flags[sfc_pkg::FlRaw] ? LenW'(n_pos) : n_lrl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fstart_q <= '0;
			phase_q <= PH_AWAIT;
			kind_q <= '0;
			skip_q <= '0;
			lenlo_q <= '0;
			flags_q <= '0;
			lro_q <= '0;
			lrl_q <= '0;
			halted_q <= 1'b0;
			aborted_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (accept && bytes.payload.last_byte) begin
				pos_q <= '0;
				fstart_q <= '0;
				phase_q <= PH_AWAIT;
				kind_q <= '0;
				skip_q <= '0;
				lenlo_q <= '0;
				flags_q <= '0;
				lro_q <= '0;
				lrl_q <= '0;
				halted_q <= 1'b0;
				aborted_q <= 1'b0;
				out_q <= n_out;
			end else if (accept) begin
				pos_q <= n_pos;
				fstart_q <= n_fstart;
				phase_q <= n_phase;
				kind_q <= n_kind;
				skip_q <= n_skip;
				lenlo_q <= n_lenlo;
				flags_q <= n_flags;
				lro_q <= n_lro;
				lrl_q <= n_lrl;
				halted_q <= n_halted;
				aborted_q <= n_aborted;
			end
			if (accept && bytes.payload.last_byte) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### test/sfc_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame classifier checking package
// Byte-level model of the scanner frame walker and a scoreboard that
// compares the block's summary items with the model's.
// ----------------------------------------------------------------------------
package sfc_check_pkg;

	localparam int BufferBytes = 512;

	typedef enum logic [2:0] {
		WAIT_START,
		AT_HEADER,
		SKIPPING,
		SEEK_ETX,
		READ_RESULT_ID,
		READ_LEN_LOW,
		READ_LEN_HIGH
	} walk_state_t;

	class sfc_frame_scoreboard;
		logic [9:0]            position;
		logic [8:0]            start_pos;
		walk_state_t           walk_state;
		logic [7:0]            frame_code;
		logic [16:0]           skip_count;
		logic [7:0]            length_low;
		logic [7:0]            flags;
		logic [8:0]            resp_offset;
		logic [16:0]           resp_length;
		bit                    halted_walk;
		bit                    abort_seen;
		sfc_pkg::result_item_t pending_summaries[$];
		int                    mismatch_count;

		function new();
			clear_walk();
			mismatch_count = 0;
		endfunction

		function void clear_walk();
			position = '0;
			start_pos = '0;
			walk_state = WAIT_START;
			frame_code = '0;
			skip_count = '0;
			length_low = '0;
			flags = '0;
			resp_offset = '0;
			resp_length = '0;
			halted_walk = 0;
			abort_seen = 0;
		endfunction

		function void record_response(int flag_idx, logic [16:0] len);
			flags[flag_idx] = 1'b1;
			resp_offset = start_pos;
			resp_length = len;
		endfunction

		function void halt_on_error();
			flags[sfc_pkg::FlError] = 1'b1;
			halted_walk = 1;
		endfunction

		function void halt_on_abort();
			flags = '0;
			abort_seen = 1;
			halted_walk = 1;
		endfunction

		function void begin_skip(logic [16:0] n);
			skip_count = n;
			walk_state = SKIPPING;
		endfunction

		function void classify_type(logic [9:0] p, logic [7:0] t);
			case (t) inside
				sfc_pkg::TypeAck: begin
					flags[sfc_pkg::FlAck] = 1'b1;
					begin_skip(17'd2);
				end
				sfc_pkg::TypeNak: begin
					flags[sfc_pkg::FlNak] = 1'b1;
					begin_skip(17'd2);
				end
				sfc_pkg::TypeBusy: begin
					flags[sfc_pkg::FlBusy] = 1'b1;
					begin_skip(17'd2);
				end
				sfc_pkg::TypeResend: begin
					flags[sfc_pkg::FlResend] = 1'b1;
					begin_skip(17'd2);
				end
				sfc_pkg::TypeReply, sfc_pkg::TypeReplyPerm, sfc_pkg::TypeEvent: begin
					if (length_low == sfc_pkg::ByteNul) begin
						halt_on_error();
					end else if (length_low == sfc_pkg::ByteEtx) begin
						// Two-byte reply; the type byte opens the next frame.
						record_response(sfc_pkg::FlResp, 17'd2);
						start_pos = p[8:0];
						frame_code = t;
						walk_state = AT_HEADER;
					end else begin
						skip_count = '0;
						walk_state = SEEK_ETX;
					end
				end
				sfc_pkg::TypeStatus: begin
					skip_count = 17'd3;
					walk_state = SEEK_ETX;
				end
				sfc_pkg::TypeResult: begin
					record_response(sfc_pkg::FlResp, 17'd8);
					walk_state = READ_RESULT_ID;
				end
				sfc_pkg::TypeBarData: begin
					record_response(sfc_pkg::FlFrameData, 17'd10);
					walk_state = READ_LEN_LOW;
				end
				sfc_pkg::TypeSetupData: begin
					record_response(sfc_pkg::FlResp, 17'd10);
					walk_state = READ_LEN_LOW;
				end
				default: begin
					halt_on_abort();
				end
			endcase
		endfunction

		function void walk_byte(logic [9:0] p, logic [7:0] b);
			logic [16:0] offset;
			logic [16:0] size;
			offset = 17'(p) - 17'(start_pos);
			case (walk_state)
				WAIT_START: begin
					start_pos = p[8:0];
					frame_code = b;
					walk_state = AT_HEADER;
				end
				AT_HEADER: begin
					if (offset == 17'd1) begin
						length_low = b;
					end else if (frame_code != sfc_pkg::ByteStx) begin
						if (frame_code >= sfc_pkg::ByteFirstText) begin
							flags[sfc_pkg::FlRaw] = 1'b1;
							halted_walk = 1;
						end else begin
							halt_on_abort();
						end
					end else begin
						classify_type(p, b);
					end
				end
				SKIPPING: begin
					if (skip_count > 0)
						skip_count = skip_count - 17'd1;
					if (skip_count == 0)
						walk_state = WAIT_START;
				end
				SEEK_ETX: begin
					if (skip_count > 0) begin
						skip_count = skip_count - 17'd1;
					end else if (b == sfc_pkg::ByteEtx) begin
						record_response(sfc_pkg::FlResp, offset + 17'd1);
						walk_state = WAIT_START;
					end else if (b == sfc_pkg::ByteNul) begin
						halt_on_error();
					end
				end
				READ_RESULT_ID: begin
					if (b == sfc_pkg::ResultIdLongA || b == sfc_pkg::ResultIdLongB)
						size = 17'd14;
					else if (b == sfc_pkg::ResultIdMid)
						size = 17'd12;
					else
						size = 17'd8;
					resp_length = size;
					begin_skip(size - 17'd4);
				end
				READ_LEN_LOW: begin
					length_low = b;
					resp_length = 17'd10 + 17'(b);
					walk_state = READ_LEN_HIGH;
				end
				default: begin
					size = 17'd10 + 17'(length_low) + {1'b0, b, 8'h00};
					resp_length = size;
					begin_skip(size - 17'd5);
				end
			endcase
		endfunction

		// Called for every accepted byte; queues a summary on the final byte.
		function void note_byte(sfc_pkg::byte_item_t item);
			logic [9:0]            p;
			sfc_pkg::result_item_t summary;
			p = position;
			if (p < BufferBytes) begin
				if (!halted_walk)
					walk_byte(p, item.data_byte);
				position = p + 10'd1;
			end
			if (!item.last_byte)
				return;
			if (!halted_walk && walk_state == SEEK_ETX)
				halt_on_error();
			summary = '0;
			summary.flag_ack = flags[sfc_pkg::FlAck];
			summary.flag_nak = flags[sfc_pkg::FlNak];
			summary.flag_busy = flags[sfc_pkg::FlBusy];
			summary.flag_resend = flags[sfc_pkg::FlResend];
			summary.flag_response = flags[sfc_pkg::FlResp];
			summary.flag_frame_data = flags[sfc_pkg::FlFrameData];
			summary.flag_raw_data = flags[sfc_pkg::FlRaw];
			summary.flag_error = flags[sfc_pkg::FlError];
			summary.aborted = abort_seen;
			if (!abort_seen) begin
				summary.response_offset = resp_offset;
				summary.response_length = flags[sfc_pkg::FlRaw] ? 17'(position) : resp_length;
			end
			pending_summaries.push_back(summary);
			clear_walk();
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] ERROR: %s", $time, msg);
			mismatch_count++;
		endtask

		task compare_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		endtask

		task check_result(sfc_pkg::result_item_t got);
			sfc_pkg::result_item_t want;
			if (pending_summaries.size() == 0) begin
				report_mismatch("result item arrived with no summary outstanding");
				return;
			end
			want = pending_summaries.pop_front();
			compare_field("flag_ack", got.flag_ack, want.flag_ack);
			compare_field("flag_nak", got.flag_nak, want.flag_nak);
			compare_field("flag_busy", got.flag_busy, want.flag_busy);
			compare_field("flag_resend", got.flag_resend, want.flag_resend);
			compare_field("flag_response", got.flag_response, want.flag_response);
			compare_field("flag_frame_data", got.flag_frame_data, want.flag_frame_data);
			compare_field("flag_raw_data", got.flag_raw_data, want.flag_raw_data);
			compare_field("flag_error", got.flag_error, want.flag_error);
			compare_field("aborted", got.aborted, want.aborted);
			compare_field("response_offset", got.response_offset, want.response_offset);
			compare_field("response_length", got.response_length, want.response_length);
		endtask

		function int pending_count();
			return pending_summaries.size();
		endfunction
	endclass

endpackage

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanner frame classifier testbench
// Feeds whole scanner buffers, mostly built from well-formed frames with
// random content, and checks every summary item against a byte-level model.
// ----------------------------------------------------------------------------
module tb_top;

	logic clk;
	logic arst_n;

	sfc_stream_if #(.T(sfc_pkg::byte_item_t))   bytes_if ();
	sfc_stream_if #(.T(sfc_pkg::result_item_t)) result_if ();

	scanner_frame_classifier_top #(
		.BUFFER_BYTES(sfc_check_pkg::BufferBytes)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes_if),
		.result(result_if)
	);

	sfc_check_pkg::sfc_frame_scoreboard sb;

	// The buffer under construction, sent byte by byte with the marker on its
	// final byte.
	logic [7:0] frame_bytes[$];

	// Sender burst bookkeeping, carried across buffers so that gaps land at
	// arbitrary positions within frames and between buffers.
	int burst_left = 0;
	int gap_cycles = 0;
	int sent_bytes = 0;
	int buffers_sent = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Generous upper bound on the run; a correct run takes a small fraction.
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Both channels are observed at the rising edge. An accepted byte updates
	// the model; an accepted result item is checked against the oldest
	// summary the model has queued.
	always @(posedge clk) begin
		if (arst_n) begin
			if (bytes_if.valid && bytes_if.ready)
				sb.note_byte(bytes_if.payload);
			if (result_if.valid && result_if.ready)
				sb.check_result(result_if.payload);
		end
	end

	// Receiver stalls follow a pattern that is redrawn at random intervals:
	// always ready, coin flips, mostly stalled, or a rotating 8-bit mask.
	initial begin
		int         mode;
		int         left;
		logic [7:0] mask;
		result_if.ready = 1'b0;
		left = 0;
		mode = 0;
		mask = '0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 64);
				mask = 8'($urandom);
			end
			left--;
			case (mode)
				0: begin
					result_if.ready = 1'b1;
				end
				1: begin
					result_if.ready = 1'($urandom_range(0, 1));
				end
				2: begin
					result_if.ready = ($urandom_range(0, 5) == 0);
				end
				default: begin
					result_if.ready = mask[0];
					mask = {mask[0], mask[7:1]};
				end
			endcase
		end
	end

	// Sends the buffer in frame_bytes. Before each byte the sender may open a
	// new burst, preceded by a random idle gap (sometimes none). Valid stays
	// high across consecutive bytes of a burst.
	task automatic send_buffer();
		int i;
		for (i = 0; i < frame_bytes.size(); i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				repeat (gap_cycles) begin
					@(negedge clk);
					bytes_if.valid = 1'b0;
				end
			end
			burst_left--;
			@(negedge clk);
			bytes_if.valid = 1'b1;
			bytes_if.payload = sfc_pkg::byte_item_t'{data_byte: frame_bytes[i],
				last_byte: (i == frame_bytes.size() - 1)};
			do
				@(posedge clk);
			while (!bytes_if.ready);
		end
		sent_bytes += (frame_bytes.size() < sfc_check_pkg::BufferBytes) ?
			frame_bytes.size() : sfc_check_pkg::BufferBytes;
		buffers_sent++;
	endtask

	initial begin
		int         n_frames;
		int         body;
		int         f;
		int         k;
		logic [7:0] t;
		logic [7:0] lo;
		logic [7:0] hi;
		int         size;

		sb = new();
		arst_n = 1'b0;
		bytes_if.valid = 1'b0;
		bytes_if.payload = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed buffers. A lone zero byte: a frame that starts in the
		// last two bytes is ignored, so the summary carries no flags.
		frame_bytes = '{sfc_pkg::ByteNul};
		send_buffer();
		// A plain acknowledge frame.
		frame_bytes = '{sfc_pkg::ByteStx, 8'h41, sfc_pkg::TypeAck, sfc_pkg::ByteNul,
			sfc_pkg::ByteNul};
		send_buffer();
		// A reply whose ETX sits at offset 1; the type byte then opens what
		// turns out to be raw text, so the length is the buffer length.
		frame_bytes = '{sfc_pkg::ByteStx, sfc_pkg::ByteEtx, sfc_pkg::TypeReply, 8'h41, 8'hFF};
		send_buffer();
		// A complete reply, then a control byte in the short tail.
		frame_bytes = '{sfc_pkg::ByteStx, 8'h07, sfc_pkg::TypeReply, 8'h41, sfc_pkg::ByteEtx,
			8'h1F, sfc_pkg::ByteNul};
		send_buffer();
		// Raw barcode text from the first byte.
		frame_bytes = '{8'hFF, 8'hFF, 8'hFF};
		send_buffer();
		// A reply with a zero length byte stops on an error.
		frame_bytes = '{sfc_pkg::ByteStx, sfc_pkg::ByteNul, sfc_pkg::TypeReply, 8'h41};
		send_buffer();
		// An unknown frame type aborts.
		frame_bytes = '{sfc_pkg::ByteStx, sfc_pkg::ByteNul, 8'h99, sfc_pkg::ByteNul};
		send_buffer();

		// Random buffers, most of them strings of well-formed frames.
		while (sent_bytes < 1700 || buffers_sent < 42) begin
			frame_bytes.delete();
			if (buffers_sent == 12) begin
				// Raw text longer than the buffer limit.
				frame_bytes.push_back(8'($urandom_range(32, 255)));
				repeat (529) frame_bytes.push_back(8'($urandom));
			end else if (buffers_sent == 40) begin
				// Acknowledge frames running past the buffer limit.
				repeat (105) begin
					frame_bytes.push_back(sfc_pkg::ByteStx);
					frame_bytes.push_back(8'($urandom));
					frame_bytes.push_back(sfc_pkg::TypeAck);
					frame_bytes.push_back(8'($urandom));
					frame_bytes.push_back(8'($urandom));
				end
			end else if ($urandom_range(0, 4) == 0) begin
				// Noise, sometimes opening with STX.
				repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom));
				if ($urandom_range(0, 1) == 0)
					frame_bytes[0] = sfc_pkg::ByteStx;
			end else begin
				n_frames = $urandom_range(0, 4);
				for (f = 0; f < n_frames; f++) begin
					case ($urandom_range(0, 9))
						0, 1: begin
							case ($urandom_range(0, 3))
								0: t = sfc_pkg::TypeAck;
								1: t = sfc_pkg::TypeNak;
								2: t = sfc_pkg::TypeBusy;
								default: t = sfc_pkg::TypeResend;
							endcase
							frame_bytes.push_back(sfc_pkg::ByteStx);
							frame_bytes.push_back(8'($urandom));
							frame_bytes.push_back(t);
							frame_bytes.push_back(8'($urandom));
							frame_bytes.push_back(8'($urandom));
						end
						2, 3: begin
							case ($urandom_range(0, 2))
								0: t = sfc_pkg::TypeReply;
								1: t = sfc_pkg::TypeReplyPerm;
								default: t = sfc_pkg::TypeEvent;
							endcase
							frame_bytes.push_back(sfc_pkg::ByteStx);
							case ($urandom_range(0, 9))
								0: lo = sfc_pkg::ByteEtx;
								1: lo = sfc_pkg::ByteNul;
								default: begin
									lo = 8'($urandom_range(1, 255));
									if (lo == sfc_pkg::ByteEtx)
										lo = sfc_pkg::ByteFirstText;
								end
							endcase
							frame_bytes.push_back(lo);
							frame_bytes.push_back(t);
							body = $urandom_range(0, 8);
							for (k = 0; k < body; k++) begin
								lo = 8'($urandom_range(1, 255));
								if (lo == sfc_pkg::ByteEtx)
									lo = sfc_pkg::ByteFirstText;
								frame_bytes.push_back(lo);
							end
							frame_bytes.push_back(($urandom_range(0, 7) == 0) ?
								sfc_pkg::ByteNul : sfc_pkg::ByteEtx);
						end
						4: begin
							// Status frames skip three bytes before the ETX search,
							// so those may hold ETX or zero freely.
							frame_bytes.push_back(sfc_pkg::ByteStx);
							frame_bytes.push_back(8'($urandom));
							frame_bytes.push_back(sfc_pkg::TypeStatus);
							repeat (3) frame_bytes.push_back(8'($urandom_range(0, 4)));
							body = $urandom_range(0, 6);
							for (k = 0; k < body; k++) begin
								lo = 8'($urandom_range(1, 255));
								if (lo == sfc_pkg::ByteEtx)
									lo = sfc_pkg::ByteFirstText;
								frame_bytes.push_back(lo);
							end
							frame_bytes.push_back(($urandom_range(0, 7) == 0) ?
								sfc_pkg::ByteNul : sfc_pkg::ByteEtx);
						end
						5: begin
							case ($urandom_range(0, 3))
								0: begin
									t = sfc_pkg::ResultIdLongA;
									size = 14;
								end
								1: begin
									t = sfc_pkg::ResultIdLongB;
									size = 14;
								end
								2: begin
									t = sfc_pkg::ResultIdMid;
									size = 12;
								end
								default: begin
									t = 8'($urandom);
									size = (t == sfc_pkg::ResultIdLongA ||
										t == sfc_pkg::ResultIdLongB) ? 14 :
										(t == sfc_pkg::ResultIdMid) ? 12 : 8;
								end
							endcase
							frame_bytes.push_back(sfc_pkg::ByteStx);
							frame_bytes.push_back(8'($urandom));
							frame_bytes.push_back(sfc_pkg::TypeResult);
							frame_bytes.push_back(t);
							repeat (size - 4) frame_bytes.push_back(8'($urandom));
						end
						6, 7: begin
							t = ($urandom_range(0, 1) == 0) ? sfc_pkg::TypeBarData :
								sfc_pkg::TypeSetupData;
							lo = 8'($urandom_range(0, 24));
							// A rare high length byte makes the frame run past the end.
							hi = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'h00;
							if ($urandom_range(0, 19) == 0)
								lo = 8'($urandom);
							frame_bytes.push_back(sfc_pkg::ByteStx);
							frame_bytes.push_back(8'($urandom));
							frame_bytes.push_back(t);
							frame_bytes.push_back(lo);
							frame_bytes.push_back(hi);
							body = (hi == 0) ? 5 + lo : $urandom_range(0, 10);
							repeat (body) frame_bytes.push_back(8'($urandom));
						end
						8: begin
							// One to four stray bytes of any value.
							repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
						end
						default: begin
							frame_bytes.push_back(sfc_pkg::ByteStx);
							frame_bytes.push_back(8'($urandom));
							frame_bytes.push_back(8'($urandom));
						end
					endcase
				end
				if ($urandom_range(0, 3) == 0) begin
					frame_bytes.push_back(8'($urandom_range(32, 255)));
					repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom));
				end
				// Cut some buffers short so frames run past the end.
				if ($urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						if (frame_bytes.size() > 1)
							void'(frame_bytes.pop_back());
					end
				end
				if (frame_bytes.size() == 0)
					frame_bytes.push_back(8'($urandom));
			end
			send_buffer();
		end

		@(negedge clk);
		bytes_if.valid = 1'b0;

		// Drain: every summary must come out, and the extra edges after that
		// catch a stray item from the result register.
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		if (sb.mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
